// ===== hdl/tnf_pkg.sv =====
`timescale 1ns / 1ps

package tnf_pkg;

    localparam int BYTE_W      = 8;
    localparam int WINDOW_W    = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int NAWS_LEN    = 12;
    localparam int NAWS_IDX_W  = $clog2(NAWS_LEN);

    localparam logic [BYTE_W-1:0] BYTE_IAC  = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_DONT = 8'hFE;
    localparam logic [BYTE_W-1:0] BYTE_DO   = 8'hFD;
    localparam logic [BYTE_W-1:0] BYTE_WONT = 8'hFC;
    localparam logic [BYTE_W-1:0] BYTE_WILL = 8'hFB;
    localparam logic [BYTE_W-1:0] BYTE_SB   = 8'hFA;
    localparam logic [BYTE_W-1:0] BYTE_SE   = 8'hF0;
    localparam logic [BYTE_W-1:0] OPT_NAWS  = 8'd31;

    localparam logic [WINDOW_W-1:0] COLUMNS_RESET = 16'd80;
    localparam logic [WINDOW_W-1:0] ROWS_RESET    = 16'd24;

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_COLUMNS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_ROWS    = 1'b1;

    localparam logic CHAN_DATA  = 1'b0;
    localparam logic CHAN_REPLY = 1'b1;

    typedef enum logic [2:0] {
        PS_NORMAL = 3'd0,
        PS_IAC    = 3'd1,
        PS_OPT    = 3'd2,
        PS_SB     = 3'd3,
        PS_SB_IAC = 3'd4
    } parse_state_t;

    typedef enum logic [1:0] {
        CMD_WILL = 2'd0,
        CMD_WONT = 2'd1,
        CMD_DO   = 2'd2,
        CMD_DONT = 2'd3
    } command_t;

    // One queued job: either a data byte for the user or a full NAWS reply.
    typedef struct packed {
        logic              naws;
        logic [BYTE_W-1:0] data;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [BYTE_W-1:0] naws_byte(
        input logic [NAWS_IDX_W-1:0] idx,
        input logic [WINDOW_W-1:0]   cols,
        input logic [WINDOW_W-1:0]   rows
    );
        logic [BYTE_W-1:0] b;
        unique case (idx)
            4'd0:    b = BYTE_IAC;
            4'd1:    b = BYTE_WILL;
            4'd2:    b = OPT_NAWS;
            4'd3:    b = BYTE_IAC;
            4'd4:    b = BYTE_SB;
            4'd5:    b = OPT_NAWS;
            4'd6:    b = cols[15:8];
            4'd7:    b = cols[7:0];
            4'd8:    b = rows[15:8];
            4'd9:    b = rows[7:0];
            4'd10:   b = BYTE_IAC;
            4'd11:   b = BYTE_SE;
            default: b = BYTE_IAC;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/telnet_iac_filter_naws_reply.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports                                        Transfer when
// input     in         s_valid, s_ready, s_rx_byte                  s_valid && s_ready
// result    out        m_valid, m_ready, m_channel, m_out_byte,     m_valid && m_ready
//                      m_last_of_run
// config    in         cfg_wr_en, cfg_index, cfg_wr_data            cfg_wr_en
//
// The parser takes one byte per cycle while its four-entry job queue has room.
// A data byte moves from its queue slot to the output register and leaves at one
// per cycle while m_ready is high; a NAWS reply occupies the output for its 12 bytes.
// Reset is synchronous and active low; the window size returns to 80 x 24.
// A stalled output fills the queue, and s_ready drops only when it is full.

module telnet_iac_filter_naws_reply (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [tnf_pkg::BYTE_W-1:0]     s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_channel,
    output logic [tnf_pkg::BYTE_W-1:0]     m_out_byte,
    output logic                           m_last_of_run,
    input  logic                           cfg_wr_en,
    input  logic [tnf_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [tnf_pkg::WINDOW_W-1:0]   cfg_wr_data
);

    logic [tnf_pkg::WINDOW_W-1:0] window_columns_reg, window_rows_reg;
    logic                         in_fire;
    logic                         push, pop;
    tnf_pkg::job_t                push_job, head_job;
    tnf_pkg::queue_status_t       q_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_columns_reg <= tnf_pkg::COLUMNS_RESET;
            window_rows_reg    <= tnf_pkg::ROWS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tnf_pkg::REG_WINDOW_COLUMNS: window_columns_reg <= cfg_wr_data;
                tnf_pkg::REG_WINDOW_ROWS:    window_rows_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign s_ready = !q_status.full;
    assign in_fire = s_valid && s_ready;

    tnf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_byte  (s_rx_byte),
        .push     (push),
        .push_job (push_job)
    );

    tnf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    tnf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_job       (head_job),
        .queue_empty    (q_status.empty),
        .pop            (pop),
        .window_columns (window_columns_reg),
        .window_rows    (window_rows_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_channel      (m_channel),
        .m_out_byte     (m_out_byte),
        .m_last_of_run  (m_last_of_run)
    );

`ifndef ASSERT_OFF
    // A job is never queued into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_status.full))
        else $error("job pushed into full queue");

    // Every user data byte is the only result of its input byte.
    a_data_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_channel == tnf_pkg::CHAN_DATA) |-> m_last_of_run)
        else $error("data byte without last_of_run");

    // A reply burst continues without gaps once started.
    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_channel == tnf_pkg::CHAN_REPLY && !m_last_of_run)
        |=> (m_valid && m_channel == tnf_pkg::CHAN_REPLY))
        else $error("reply burst interrupted");
`endif

endmodule

// ===== hdl/tnf_front.sv =====
`timescale 1ns / 1ps

module tnf_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_fire,
    input  logic [tnf_pkg::BYTE_W-1:0] in_byte,
    output logic                       push,
    output tnf_pkg::job_t              push_job
);

    tnf_pkg::parse_state_t state_reg, state_next;
    tnf_pkg::command_t     pending_reg, pending_next;
    logic [tnf_pkg::BYTE_W-1:0] cmd_offset;

    assign cmd_offset = in_byte - tnf_pkg::BYTE_WILL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tnf_pkg::PS_NORMAL;
            pending_reg <= tnf_pkg::CMD_WILL;
        end else if (in_fire) begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    always_comb begin
        state_next   = tnf_pkg::PS_NORMAL;
        pending_next = pending_reg;
        unique case (state_reg)
            tnf_pkg::PS_IAC: begin
                if (in_byte == tnf_pkg::BYTE_SB) begin
                    state_next = tnf_pkg::PS_SB;
                end else if (in_byte >= tnf_pkg::BYTE_WILL && in_byte <= tnf_pkg::BYTE_DONT) begin
                    state_next   = tnf_pkg::PS_OPT;
                    pending_next = tnf_pkg::command_t'(cmd_offset[1:0]);
                end
            end
            tnf_pkg::PS_OPT: state_next = tnf_pkg::PS_NORMAL;
            tnf_pkg::PS_SB: begin
                state_next = (in_byte == tnf_pkg::BYTE_IAC) ? tnf_pkg::PS_SB_IAC
                                                            : tnf_pkg::PS_SB;
            end
            tnf_pkg::PS_SB_IAC: begin
                state_next = (in_byte == tnf_pkg::BYTE_SE) ? tnf_pkg::PS_NORMAL
                                                           : tnf_pkg::PS_SB;
            end
            default: begin
                state_next = (in_byte == tnf_pkg::BYTE_IAC) ? tnf_pkg::PS_IAC
                                                            : tnf_pkg::PS_NORMAL;
            end
        endcase
    end

    always_comb begin
        push          = 1'b0;
        push_job.naws = 1'b0;
        push_job.data = in_byte;
        unique case (state_reg)
            tnf_pkg::PS_IAC: begin
                push = in_fire && (in_byte == tnf_pkg::BYTE_IAC);
            end
            tnf_pkg::PS_OPT: begin
                push_job.naws = 1'b1;
                push = in_fire && (pending_reg == tnf_pkg::CMD_DO)
                       && (in_byte == tnf_pkg::OPT_NAWS);
            end
            tnf_pkg::PS_SB, tnf_pkg::PS_SB_IAC: push = 1'b0;
            default: push = in_fire && (in_byte != tnf_pkg::BYTE_IAC);
        endcase
    end

endmodule

// ===== hdl/tnf_queue.sv =====
`timescale 1ns / 1ps

module tnf_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  tnf_pkg::job_t          push_job,
    input  logic                   pop,
    output tnf_pkg::job_t          head_job,
    output tnf_pkg::queue_status_t status
);

    tnf_pkg::job_t                       slot_reg [tnf_pkg::QUEUE_DEPTH];
    logic [tnf_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [tnf_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic                                do_push, do_pop;

    assign status.full  = (count_reg == tnf_pkg::QUEUE_CNT_W'(tnf_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== hdl/tnf_back.sv =====
`timescale 1ns / 1ps

module tnf_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tnf_pkg::job_t                head_job,
    input  logic                         queue_empty,
    output logic                         pop,
    input  logic [tnf_pkg::WINDOW_W-1:0] window_columns,
    input  logic [tnf_pkg::WINDOW_W-1:0] window_rows,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_channel,
    output logic [tnf_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                         m_last_of_run
);

    localparam logic [tnf_pkg::NAWS_IDX_W-1:0] LAST_IDX =
        tnf_pkg::NAWS_IDX_W'(tnf_pkg::NAWS_LEN - 1);

    logic                              out_valid_reg, out_valid_next;
    logic                              out_channel_reg, out_channel_next;
    logic [tnf_pkg::BYTE_W-1:0]        out_byte_reg, out_byte_next;
    logic                              out_last_reg, out_last_next;
    logic                              burst_reg, burst_next;
    logic [tnf_pkg::NAWS_IDX_W-1:0]    idx_reg, idx_next;
    logic                              load_ok;

    // The output register takes a new result whenever it is empty or being drained.
    assign load_ok = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next   = out_valid_reg;
        out_channel_next = out_channel_reg;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        burst_next       = burst_reg;
        idx_next         = idx_reg;
        pop              = 1'b0;
        if (load_ok) begin
            if (burst_reg) begin
                out_valid_next   = 1'b1;
                out_channel_next = tnf_pkg::CHAN_REPLY;
                out_byte_next    = tnf_pkg::naws_byte(idx_reg, window_columns, window_rows);
                out_last_next    = (idx_reg == LAST_IDX);
                burst_next       = (idx_reg != LAST_IDX);
                idx_next         = idx_reg + 1'b1;
            end else if (!queue_empty) begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (head_job.naws) begin
                    out_channel_next = tnf_pkg::CHAN_REPLY;
                    out_byte_next    = tnf_pkg::naws_byte('0, window_columns, window_rows);
                    out_last_next    = 1'b0;
                    burst_next       = 1'b1;
                    idx_next         = tnf_pkg::NAWS_IDX_W'(1);
                end else begin
                    out_channel_next = tnf_pkg::CHAN_DATA;
                    out_byte_next    = head_job.data;
                    out_last_next    = 1'b1;
                end
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            burst_reg     <= 1'b0;
            idx_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            burst_reg     <= burst_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_channel_reg <= out_channel_next;
        out_byte_reg    <= out_byte_next;
        out_last_reg    <= out_last_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_channel     = out_channel_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_last_of_run = out_last_reg;

endmodule
